// ===== hdl/glyph_row_expander_clipped_assert.svh =====
// assertion macros for the glyph row expander
`ifndef GLYPH_ROW_EXPANDER_CLIPPED_ASSERT_SVH
`define GLYPH_ROW_EXPANDER_CLIPPED_ASSERT_SVH

// condition implies consequence in the same cycle
`define GREC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glyph row expander check failed");

// condition implies consequence in the next cycle
`define GREC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glyph row expander check failed");

`endif

// ===== hdl/grec_pkg.sv =====
// shared types and constants of the glyph row expander
package grec_pkg;

  localparam int ROW_IDX_W    = 5;
  localparam int SCREEN_DIM_W = 14;
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int ADDR_OUT_W   = 25;
  localparam int COLOR_W      = 32;
  localparam int COLS         = 8;
  localparam int IN_DATA_W    = 120;
  localparam int OUT_DATA_W   = 296;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = 1;
  localparam int QCNT_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH    = 2'd0,
    CFG_SCREEN_HEIGHT   = 2'd1,
    CFG_DISPLAY_ENABLED = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DRAW = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] screen_width;
    logic [CFG_W-1:0] screen_height;
    logic             display_enabled;
  } cfg_t;

  typedef struct packed {
    logic                    is_load;
    logic [7:0]              code;
    logic [ROW_IDX_W-1:0]    row_first;
    logic [ROW_IDX_W-1:0]    row_last;
    logic [COLS-1:0]         mask;
    logic [ADDR_OUT_W-1:0]   base;
    logic [SCREEN_DIM_W-1:0] stride;
    logic [COLOR_W-1:0]      fg;
    logic [COLOR_W-1:0]      bg;
    logic [7:0]              load_bits;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic busy;
    logic stage_valid;
  } bk_stat_t;

endpackage

// ===== hdl/grec_front.sv =====
// front end: accepts items, clips against the screen and builds commands
module grec_front #(
  parameter int GLYPH_ROWS     = 16,
  parameter int GLYPH_COUNT    = 128,
  parameter int MAX_SCREEN_DIM = 4096
) (
  input  grec_pkg::cfg_t                      cfg,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [grec_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                                s_tuser,
  input  logic                                q_full,
  output grec_pkg::q_push_t                   push
);
  import grec_pkg::*;

  logic signed [15:0]      pos_x;
  logic signed [15:0]      pos_y;
  logic [7:0]              char_code;
  logic [COLOR_W-1:0]      fg_color;
  logic [COLOR_W-1:0]      bg_color;
  logic [3:0]              load_row;
  logic [7:0]              load_bits;
  logic [SCREEN_DIM_W-1:0] w_c;
  logic [SCREEN_DIM_W-1:0] h_c;
  logic signed [17:0]      xs;
  logic signed [17:0]      ys;
  logic signed [17:0]      w_s;
  logic signed [17:0]      h_s;
  logic signed [17:0]      px;
  logic signed [17:0]      lim;
  logic [COLS-1:0]         mask;
  logic                    vis_y;
  logic                    code_ok;
  logic                    keep;
  logic [15:0]             py0;
  logic [29:0]             prod;
  logic [ROW_IDX_W-1:0]    first_row;
  logic [ROW_IDX_W-1:0]    last_row;

  assign pos_x     = s_tdata[15:0];
  assign pos_y     = s_tdata[31:16];
  assign char_code = s_tdata[39:32];
  assign fg_color  = s_tdata[71:40];
  assign bg_color  = s_tdata[103:72];
  assign load_row  = s_tdata[107:104];
  assign load_bits = s_tdata[115:108];

  assign s_tready = !q_full;

  always_comb begin
    w_c = (SCREEN_DIM_W'(cfg.screen_width) > SCREEN_DIM_W'(MAX_SCREEN_DIM)) ?
          SCREEN_DIM_W'(MAX_SCREEN_DIM) : SCREEN_DIM_W'(cfg.screen_width);
    h_c = (SCREEN_DIM_W'(cfg.screen_height) > SCREEN_DIM_W'(MAX_SCREEN_DIM)) ?
          SCREEN_DIM_W'(MAX_SCREEN_DIM) : SCREEN_DIM_W'(cfg.screen_height);
    xs  = 18'(pos_x);
    ys  = 18'(pos_y);
    w_s = $signed({4'b0, w_c});
    h_s = $signed({4'b0, h_c});

    // horizontal clip, one compare pair per column
    mask = '0;
    px   = '0;
    for (int k = 0; k < COLS; k++) begin
      px      = xs + $signed(18'(k));
      mask[k] = (px >= 18'sd0) && (px < w_s);
    end

    // visible rows form one contiguous run; a zero height shows nothing
    vis_y = ((ys + $signed(18'(GLYPH_ROWS - 1))) >= 18'sd0) && (ys < h_s) &&
            (h_s > 18'sd0);
    first_row = ys[17] ? ROW_IDX_W'(-ys) : '0;
    lim = h_s - 18'sd1 - ys;
    last_row = (lim < $signed(18'(GLYPH_ROWS - 1))) ? ROW_IDX_W'(lim)
                                                    : ROW_IDX_W'(GLYPH_ROWS - 1);

    py0  = ys[17] ? 16'd0 : ys[15:0];
    prod = 30'(py0) * 30'(w_c);

    code_ok = {1'b0, char_code} < 9'(GLYPH_COUNT);
    if (s_tuser == OP_LOAD) begin
      keep = code_ok && ({2'b0, load_row} < 6'(GLYPH_ROWS));
    end else begin
      keep = cfg.display_enabled && code_ok && vis_y && (mask != '0);
    end

    push.push          = s_tvalid && s_tready && keep;
    push.cmd.is_load   = (s_tuser == OP_LOAD);
    push.cmd.code      = char_code;
    push.cmd.row_first = (s_tuser == OP_LOAD) ? ROW_IDX_W'(load_row) : first_row;
    push.cmd.row_last  = last_row;
    push.cmd.mask      = mask;
    push.cmd.base      = prod[ADDR_OUT_W-1:0] + {{9{pos_x[15]}}, pos_x};
    push.cmd.stride    = w_c;
    push.cmd.fg        = fg_color;
    push.cmd.bg        = bg_color;
    push.cmd.load_bits = load_bits;
  end

endmodule

// ===== hdl/grec_queue.sv =====
// short command queue between front and back end
module grec_queue (
  input  logic              clk,
  input  logic              rst,
  input  grec_pkg::q_push_t push,
  input  logic              pop,
  output grec_pkg::q_head_t head,
  output logic              full,
  output logic [grec_pkg::QCNT_W-1:0] count
);
  import grec_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count_next;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];

  always_comb begin
    count_next = count;
    case ({push.push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      slots[wr_ptr] <= push.cmd;
    end
  end

endmodule

// ===== hdl/grec_back.sv =====
// back end: glyph store, row sequencer and result register
module grec_back #(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  grec_pkg::q_head_t                 head,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [grec_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                              m_tlast,
  output grec_pkg::bk_stat_t                stat
);
  import grec_pkg::*;

  localparam int GLYPH_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int ADDR_W      = $clog2(GLYPH_DEPTH);

  logic [7:0]            glyph_mem [GLYPH_DEPTH];

  back_state_t           state;
  back_state_t           state_next;
  cmd_t                  cur;
  logic [ROW_IDX_W-1:0]  row;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     head_addr;
  logic [ADDR_OUT_W-1:0] cur_addr;

  // read stage
  logic                  b_valid;
  logic [7:0]            b_bits;
  logic [ADDR_OUT_W-1:0] b_addr;
  logic [COLS-1:0]       b_mask;
  logic [COLOR_W-1:0]    b_fg;
  logic [COLOR_W-1:0]    b_bg;
  logic                  b_last;

  // result register
  logic                  out_valid;
  logic [ADDR_OUT_W-1:0] out_addr;
  logic [COLS-1:0]       out_mask;
  logic [COLOR_W-1:0]    out_pix [COLS];
  logic                  out_last;

  logic start;
  logic do_load;
  logic issue;
  logic move_out;
  logic b_free;

  assign head_addr = ADDR_W'(head.cmd.code) * ADDR_W'(GLYPH_ROWS)
                   + ADDR_W'(head.cmd.row_first);

  assign move_out = b_valid && (!out_valid || m_tready);
  assign b_free   = !b_valid || move_out;

  always_comb begin
    state_next = state;
    start      = 1'b0;
    do_load    = 1'b0;
    issue      = 1'b0;
    pop        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.cmd.is_load) begin
            do_load = 1'b1;
          end else begin
            start      = 1'b1;
            state_next = ST_DRAW;
          end
        end
      end
      ST_DRAW: begin
        if (b_free) begin
          issue = 1'b1;
          if (row == cur.row_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      glyph_mem[head_addr] <= head.cmd.load_bits;
    end
    if (issue) begin
      b_bits <= glyph_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur      <= head.cmd;
      row      <= head.cmd.row_first;
      rd_addr  <= head_addr;
      cur_addr <= head.cmd.base;
    end else if (issue) begin
      row      <= row + 1'b1;
      rd_addr  <= rd_addr + 1'b1;
      cur_addr <= cur_addr + ADDR_OUT_W'(cur.stride);
    end
    if (issue) begin
      b_addr <= cur_addr;
      b_mask <= cur.mask;
      b_fg   <= cur.fg;
      b_bg   <= cur.bg;
      b_last <= (row == cur.row_last);
    end
    if (move_out) begin
      out_addr <= b_addr;
      out_mask <= b_mask;
      out_last <= b_last;
      for (int k = 0; k < COLS; k++) begin
        out_pix[k] <= b_bits[COLS-1-k] ? b_fg : b_bg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        b_valid <= 1'b1;
      end else if (move_out) begin
        b_valid <= 1'b0;
      end
      if (move_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {7'b0, out_pix[7], out_pix[6], out_pix[5], out_pix[4],
                     out_pix[3], out_pix[2], out_pix[1], out_pix[0],
                     out_mask, out_addr};

  assign stat.busy        = (state == ST_DRAW);
  assign stat.stage_valid = b_valid;

endmodule

// ===== hdl/glyph_row_expander_clipped.sv =====
// top level of the clipped 8-pixel glyph row expander
//
//  channel   dir   handshake                 payload
//  s_*       in    s_tvalid / s_tready       s_tdata, s_tuser (op)
//  m_*       out   m_tvalid / m_tready       m_tdata, m_tlast (last row)
//  cfg_*     in    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// a draw keeps the back end busy from its start until its last visible glyph
// row is issued; rows leave the glyph store read port at one per cycle while
// the read stage can take them; a load is written from idle, the front end
// takes one transaction per cycle while the two-entry command queue has room
// reset clears control state only; the glyph store holds garbage until loaded
// either side may stall: the result register and read stage hold their rows
`include "glyph_row_expander_clipped_assert.svh"

module glyph_row_expander_clipped #(
  parameter int GLYPH_ROWS     = 16,
  parameter int GLYPH_COUNT    = 128,
  parameter int MAX_SCREEN_DIM = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  // input transaction
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [15:0] pos_x, [31:16] pos_y, [39:32] char_code, [71:40] fg_color,
  // [103:72] bg_color, [107:104] load_row, [115:108] load_bits
  input  logic [grec_pkg::IN_DATA_W-1:0]      s_tdata,
  // [0] op
  input  logic                                s_tuser,
  // result transaction
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [24:0] row_address, [32:25] write_mask, [64:33] pixel0_color,
  // [96:65] pixel1_color, [128:97] pixel2_color, [160:129] pixel3_color,
  // [192:161] pixel4_color, [224:193] pixel5_color, [256:225] pixel6_color,
  // [288:257] pixel7_color
  output logic [grec_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tlast,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [grec_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [grec_pkg::CFG_W-1:0]          cfg_data
);
  import grec_pkg::*;

  cfg_t              cfg;
  q_push_t           q_push;
  q_head_t           q_head;
  logic              q_pop;
  logic              q_full;
  logic [QCNT_W-1:0] q_count;
  bk_stat_t          bk_stat;

  // register file, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width    <= CFG_W'(1024);
      cfg.screen_height   <= CFG_W'(768);
      cfg.display_enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:    cfg.screen_width    <= cfg_data;
        CFG_SCREEN_HEIGHT:   cfg.screen_height   <= cfg_data;
        CFG_DISPLAY_ENABLED: cfg.display_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // classify and clip, one transaction per cycle while the queue has room
  grec_front #(
    .GLYPH_ROWS     (GLYPH_ROWS),
    .GLYPH_COUNT    (GLYPH_COUNT),
    .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
  ) u_front (
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (q_push)
  );

  // loads travel with draws so they never overtake a pending draw
  grec_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .count (q_count)
  );

  // glyph store and row sequencer
  grec_back #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .stat     (bk_stat)
  );

  // every emitted row has at least one pixel on screen
  `GREC_ASSERT_NOW(a_mask_nonzero, m_tvalid, m_tdata[32:25] != 8'd0)
  // queue never overfills
  `GREC_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= QCNT_W'(QUEUE_DEPTH))
  // a new result only comes out of a filled read stage
  `GREC_ASSERT_NEXT(a_out_from_stage, !bk_stat.stage_valid, !$rose(m_tvalid))
  // a draw in progress never coexists with a pop of the queue
  `GREC_ASSERT_NOW(a_no_pop_busy, bk_stat.busy, !q_pop)

endmodule
